### sv/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, muted in reset.
`define PTME_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, muted in reset.
`define PTME_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/ptme_pkg.sv
// Types and constants of the page table map/unmap engine.
`default_nettype none

package ptme_pkg;

    // Command codes
    localparam logic [1:0] CMD_MAP_4K   = 2'd0;
    localparam logic [1:0] CMD_UNMAP_4K = 2'd1;
    localparam logic [1:0] CMD_MAP_2M   = 2'd2;
    localparam logic [1:0] CMD_UNMAP_2M = 2'd3;

    // Status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_NO_MEMORY  = 2'd1;
    localparam logic [1:0] STATUS_EXISTS     = 2'd2;
    localparam logic [1:0] STATUS_NOT_MAPPED = 2'd3;

    // Walk levels, root first
    localparam logic [1:0] LVL_PML4 = 2'd3;
    localparam logic [1:0] LVL_PDPT = 2'd2;
    localparam logic [1:0] LVL_PD   = 2'd1;
    localparam logic [1:0] LVL_PT   = 2'd0;

    // Low attribute bits of a table entry
    localparam logic [11:0] ENTRY_PRESENT = 12'h001;
    localparam logic [11:0] ENTRY_RW      = 12'h002;
    localparam logic [11:0] ENTRY_PS      = 12'h080;

    localparam int IDX_W   = 9;
    localparam int FRAME_W = 40;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [47:0] virt_addr;
        logic [51:0] phys_addr;
        logic [11:0] entry_flags;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [51:0] freed_phys_addr;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_CLEAR,   // root table sweep after reset
        ST_IDLE,
        ST_READ,    // issue table read for the current level
        ST_EVAL,    // judge the entry just read
        ST_ZERO,    // sweep of a freshly allocated table
        ST_FINISH   // hand the result to the output register
    } t_state;

endpackage

`default_nettype wire

### sv/page_table_map_unmap_engine_core.sv
// Page table map/unmap engine: walk sequencer, table store and result register.
`default_nettype none

// Each table level walked takes one store read (ST_READ) and one evaluation (ST_EVAL);
//   each table allocated is swept clear entry by entry (ST_ZERO) before the walk
//   descends into it, and the result is posted from ST_FINISH. The engine takes one
//   item at a time; the input reopens the cycle after posting, later while the result register stalls.
// Reset: synchronous active low; the root table is then swept clear with o_in_stall
//   high, and the allocator restarts at table 1.
module page_table_map_unmap_engine_core #(
    parameter int TABLE_PAGES = 64
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  ptme_pkg::t_in_item    i_in_item,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output ptme_pkg::t_out_item   o_out_item
);

    localparam int TBL_W  = $clog2(TABLE_PAGES);
    localparam int ADDR_W = TBL_W + ptme_pkg::IDX_W;
    localparam int DEPTH  = TABLE_PAGES * (2 ** ptme_pkg::IDX_W);
    localparam int NFT_W  = $clog2(TABLE_PAGES + 1);

    // Sequencer state
    ptme_pkg::t_state r_state, n_state;

    // Latched command (payload, no reset)
    logic [1:0]                      r_cmd, n_cmd;
    logic [35:0]                     r_va, n_va;      // virt_addr[47:12]
    logic [ptme_pkg::FRAME_W-1:0]    r_pa, n_pa;      // phys_addr[51:12]
    logic [11:0]                     r_fl, n_fl;

    // Walk position
    logic [1:0]                      r_lvl, n_lvl;
    logic [TBL_W-1:0]                r_tbl, n_tbl;

    // Allocator and clear sweep
    logic [NFT_W-1:0]                r_nft, n_nft;
    logic [TBL_W-1:0]                r_new_tbl, n_new_tbl;
    logic [ptme_pkg::IDX_W-1:0]      r_clr_cnt, n_clr_cnt;

    // Result being built
    logic [1:0]                      r_status, n_status;
    logic [ptme_pkg::FRAME_W-1:0]    r_freed, n_freed;

    // Output register
    logic                            r_out_valid, n_out_valid;
    ptme_pkg::t_out_item             r_out_item, n_out_item;

    // Table store
    logic [63:0]                     mem [DEPTH];
    logic [63:0]                     r_rd_data;
    logic                            mem_re, mem_we;
    logic [ADDR_W-1:0]               mem_raddr, mem_waddr;
    logic [63:0]                     mem_wdata;

    // Entry decode helpers
    logic [ptme_pkg::IDX_W-1:0]      idx;
    logic [ADDR_W-1:0]               cur_addr;
    logic [ptme_pkg::FRAME_W-1:0]    e_frame;
    logic [TBL_W-1:0]                child_tbl;
    logic                            e_present, e_ps;
    logic                            is_map, is_2m, at_leaf, pool_empty, out_free;
    logic [1:0]                      leaf_lvl;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_raddr];
        end
    end

    // Per-level 9-bit index out of the virtual address
    always_comb begin
        unique case (r_lvl)
            ptme_pkg::LVL_PML4: idx = r_va[35:27];
            ptme_pkg::LVL_PDPT: idx = r_va[26:18];
            ptme_pkg::LVL_PD:   idx = r_va[17:9];
            ptme_pkg::LVL_PT:   idx = r_va[8:0];
            default:            idx = r_va[8:0];
        endcase
    end

    assign cur_addr   = {r_tbl, idx};
    assign e_present  = r_rd_data[0];
    assign e_ps       = r_rd_data[7];
    assign e_frame    = r_rd_data[51:12];
    // Links that point past the pool fall back to the root
    assign child_tbl  = (e_frame < ptme_pkg::FRAME_W'(TABLE_PAGES)) ?
                        e_frame[TBL_W-1:0] : '0;
    assign is_map     = (r_cmd == ptme_pkg::CMD_MAP_4K) || (r_cmd == ptme_pkg::CMD_MAP_2M);
    assign is_2m      = (r_cmd == ptme_pkg::CMD_MAP_2M) || (r_cmd == ptme_pkg::CMD_UNMAP_2M);
    assign leaf_lvl   = is_2m ? ptme_pkg::LVL_PD : ptme_pkg::LVL_PT;
    assign at_leaf    = (r_lvl == leaf_lvl);
    assign pool_empty = (r_nft >= NFT_W'(TABLE_PAGES));
    assign out_free   = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ptme_pkg::ST_CLEAR;
            r_nft       <= NFT_W'(1);
            r_new_tbl   <= '0;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_nft       <= n_nft;
            r_new_tbl   <= n_new_tbl;
            r_clr_cnt   <= n_clr_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_va       <= n_va;
        r_pa       <= n_pa;
        r_fl       <= n_fl;
        r_lvl      <= n_lvl;
        r_tbl      <= n_tbl;
        r_status   <= n_status;
        r_freed    <= n_freed;
        r_out_item <= n_out_item;
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_va        = r_va;
        n_pa        = r_pa;
        n_fl        = r_fl;
        n_lvl       = r_lvl;
        n_tbl       = r_tbl;
        n_nft       = r_nft;
        n_new_tbl   = r_new_tbl;
        n_clr_cnt   = r_clr_cnt;
        n_status    = r_status;
        n_freed     = r_freed;
        n_out_item  = r_out_item;
        // a waiting result leaves once the consumer stops stalling
        n_out_valid = r_out_valid && i_out_stall;
        mem_re      = 1'b0;
        mem_raddr   = cur_addr;
        mem_we      = 1'b0;
        mem_waddr   = cur_addr;
        mem_wdata   = '0;

        unique case (r_state)
            ptme_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = {r_new_tbl, r_clr_cnt};
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (&r_clr_cnt) begin
                    n_state = ptme_pkg::ST_IDLE;
                end
            end

            ptme_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_in_item.cmd;
                    n_va    = i_in_item.virt_addr[47:12];
                    n_pa    = i_in_item.phys_addr[51:12];
                    n_fl    = i_in_item.entry_flags;
                    n_lvl   = ptme_pkg::LVL_PML4;
                    n_tbl   = '0;
                    n_state = ptme_pkg::ST_READ;
                end
            end

            ptme_pkg::ST_READ: begin
                mem_re  = 1'b1;
                n_state = ptme_pkg::ST_EVAL;
            end

            ptme_pkg::ST_EVAL: begin
                n_status = ptme_pkg::STATUS_OK;
                n_freed  = '0;
                n_state  = ptme_pkg::ST_FINISH;
                if (is_map) begin
                    if (at_leaf) begin
                        if (e_present) begin
                            n_status = ptme_pkg::STATUS_EXISTS;
                        end else begin
                            mem_we    = 1'b1;
                            mem_wdata = {12'd0, r_pa,
                                         r_fl | ptme_pkg::ENTRY_PRESENT |
                                         (is_2m ? ptme_pkg::ENTRY_PS : 12'd0)};
                        end
                    end else if (e_present) begin
                        // a large page in the way of a deeper walk
                        if (e_ps) begin
                            n_status = ptme_pkg::STATUS_EXISTS;
                        end else begin
                            n_tbl   = child_tbl;
                            n_lvl   = r_lvl - 2'd1;
                            n_state = ptme_pkg::ST_READ;
                        end
                    end else if (pool_empty) begin
                        n_status = ptme_pkg::STATUS_NO_MEMORY;
                    end else begin
                        // link the new table now, clear it, then descend into it
                        mem_we    = 1'b1;
                        mem_wdata = {12'd0, ptme_pkg::FRAME_W'(r_nft),
                                     ptme_pkg::ENTRY_PRESENT | ptme_pkg::ENTRY_RW};
                        n_new_tbl = r_nft[TBL_W-1:0];
                        n_nft     = r_nft + 1'b1;
                        n_clr_cnt = '0;
                        n_state   = ptme_pkg::ST_ZERO;
                    end
                end else begin
                    if (at_leaf) begin
                        if (!e_present || (is_2m && !e_ps)) begin
                            n_status = ptme_pkg::STATUS_NOT_MAPPED;
                        end else begin
                            n_freed = e_frame;
                            mem_we  = 1'b1;
                        end
                    end else if (!e_present || e_ps) begin
                        n_status = ptme_pkg::STATUS_NOT_MAPPED;
                    end else begin
                        n_tbl   = child_tbl;
                        n_lvl   = r_lvl - 2'd1;
                        n_state = ptme_pkg::ST_READ;
                    end
                end
            end

            ptme_pkg::ST_ZERO: begin
                mem_we    = 1'b1;
                mem_waddr = {r_new_tbl, r_clr_cnt};
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (&r_clr_cnt) begin
                    n_tbl   = r_new_tbl;
                    n_lvl   = r_lvl - 2'd1;
                    n_state = ptme_pkg::ST_READ;
                end
            end

            ptme_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_out_valid                = 1'b1;
                    n_out_item.status          = r_status;
                    n_out_item.freed_phys_addr = {r_freed, 12'd0};
                    n_state                    = ptme_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = ptme_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != ptme_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

### sv/ptme_checker.sv
// Port-level checks of the page table engine, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module ptme_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_in_valid,
    input wire                  i_in_stall,
    input wire                  i_out_valid,
    input wire                  i_out_stall,
    input ptme_pkg::t_out_item  i_out_item
);

    `PTME_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid && $stable(i_out_item), "stalled result changed")

    `PTME_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !i_in_stall, i_in_stall, "engine took a second item while walking")

    `PTME_ASSERT_SAME(a_freed_only_ok, i_clk, i_rst_n, i_out_valid && (i_out_item.status != ptme_pkg::STATUS_OK), i_out_item.freed_phys_addr == 52'd0, "freed address on a failed command")

    `PTME_ASSERT_SAME(a_freed_page_aligned, i_clk, i_rst_n, i_out_valid, i_out_item.freed_phys_addr[11:0] == 12'd0, "freed address not page aligned")

endmodule

bind page_table_map_unmap_engine_core ptme_checker u_ptme_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_item  (o_out_item)
);

`default_nettype wire
